// File: rtl/ppmc_pkg.sv
// ============================================================================
// Panel pot and mode controller package
// Shared types, codes and a helper function for the panel controller.
// ============================================================================
package ppmc_pkg;

    localparam int PotCount = 4;

    typedef struct packed {
        logic        func;
        logic [1:0]  pot_index;
        logic [15:0] pot_raw;
        logic        button;
        logic [15:0] press_ms;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic        target;
        logic [1:0]  param_index;
        logic [15:0] param_value;
        logic [3:0]  proc_function;
        logic        control_mode;
        logic [1:0]  edit_mode_now;
        logic [2:0]  panel_function;
        logic        last;
    } t_out_item;

    // Result kinds.
    localparam logic [1:0] KIND_PARAM = 2'd0;
    localparam logic [1:0] KIND_FUNC  = 2'd1;
    localparam logic [1:0] KIND_CMODE = 2'd2;

    // Edit modes.
    localparam logic [1:0] EM_TWIN    = 2'd0;
    localparam logic [1:0] EM_SPLIT   = 2'd1;
    localparam logic [1:0] EM_EXPERT1 = 2'd2;
    localparam logic [1:0] EM_EXPERT2 = 2'd3;

    // Threshold classes.
    localparam logic [1:0] CLS_NONE     = 2'd0;
    localparam logic [1:0] CLS_UNLOCKED = 2'd1;
    localparam logic [1:0] CLS_LOCKED   = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_SNAP     = 2'd0;
    localparam logic [1:0] REG_LONG     = 2'd1;
    localparam logic [1:0] REG_UNLOCKED = 2'd2;
    localparam logic [1:0] REG_LOCKED   = 2'd3;

    localparam logic [7:0] SNAP_WINDOW = 8'd2;

    // Commands from the controller to the datapath.
    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_POT,
        CMD_EDIT_LONG,
        CMD_EDIT_SHORT,
        CMD_FUNC
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_EMIT
    } t_state;

    typedef struct packed {
        t_cmd cmd;
        logic load_item;
        logic emit_step;
    } t_ctrl;

    typedef struct packed {
        logic [3:0] res_count;
    } t_status;

    // Panel function to processor function code for one channel.
    function automatic logic [3:0] proc_code(input logic [2:0] f, input logic ch);
        logic [3:0] r;
        if (f < 3'd3) r = {1'b0, f};
        else if (f == 3'd3) r = 4'd3 + {3'b0, ch};
        else r = {1'b0, f} + 4'd1;
        return r;
    endfunction

endpackage

// File: rtl/panel_pot_and_mode_controller_unit.sv
// ============================================================================
// Panel pot and mode controller
// Top level joining the sequencer and the datapath.
// ============================================================================
// Usage: present one input transaction (pot sample or button release) with
// i_in_valid; it is taken when i_in_valid is high and o_in_stall is low.
// Each item passes through capture and state update and then plays out the
// results it causes, up to twelve results for an edit mode change; the
// sequencer handles one item at a time, so o_in_stall stays high until the
// final result (o_out_item.last) has been taken. An item that causes no
// result frees the input once the sequencer has passed its emit state.
// Results appear on o_out_valid/o_out_item; a high i_out_stall holds the
// current result unchanged until it is taken.
// Configuration writes use i_cfg_valid/o_cfg_ready, always ready; the user must
// make them only while the block is idle, which the block does not enforce.
// Synchronous active-low reset restores default registers, clears filters,
// thresholds and stored values, and sets twin mode with panel function 0.
module panel_pot_and_mode_controller_unit
    import ppmc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_ctrl      w_ctrl;
    t_status    w_status;
    logic       w_func, w_button, w_is_long, w_last;
    logic [3:0] w_idx;

    assign o_cfg_ready = 1'b1;

    ppmc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in_valid),
        .i_func     (w_func),
        .i_button   (w_button),
        .i_is_long  (w_is_long),
        .i_out_stall(i_out_stall),
        .i_status   (w_status),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .o_last     (w_last),
        .o_res_idx  (w_idx),
        .o_ctrl     (w_ctrl)
    );

    ppmc_datapath u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (i_in_item),
        .i_ctrl    (w_ctrl),
        .i_res_idx (w_idx),
        .i_last    (w_last),
        .i_cfg_we  (i_cfg_valid),
        .i_cfg_idx (i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .o_func    (w_func),
        .o_button  (w_button),
        .o_is_long (w_is_long),
        .o_status  (w_status),
        .o_item    (o_out_item)
    );

endmodule

// File: rtl/ppmc_ctrl.sv
// ============================================================================
// Panel controller sequencer
// Accepts one transaction, runs the datapath step, then plays out results.
// ============================================================================
module ppmc_ctrl
    import ppmc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  logic      i_func,
    input  logic      i_button,
    input  logic      i_is_long,
    input  logic      i_out_stall,
    input  t_status   i_status,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output logic      o_last,
    output logic [3:0] o_res_idx,
    output t_ctrl     o_ctrl
);

    t_state     r_state, n_state;
    logic [3:0] r_idx, n_idx;

    // State and result index registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    // Next state and command decode.
    always_comb begin
        n_state        = r_state;
        n_idx          = r_idx;
        o_ctrl.cmd       = CMD_NONE;
        o_ctrl.load_item = 1'b0;
        o_ctrl.emit_step = 1'b0;
        o_in_stall     = 1'b1;
        o_out_valid    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_valid) begin
                    o_ctrl.load_item = 1'b1;
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!i_func) o_ctrl.cmd = CMD_POT;
                else if (i_button) o_ctrl.cmd = CMD_FUNC;
                else if (i_is_long) o_ctrl.cmd = CMD_EDIT_LONG;
                else o_ctrl.cmd = CMD_EDIT_SHORT;
                n_idx   = '0;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_status.res_count == 4'd0) begin
                    n_state = ST_IDLE;
                end else begin
                    o_out_valid = 1'b1;
                    if (!i_out_stall) begin
                        o_ctrl.emit_step = 1'b1;
                        n_idx = r_idx + 4'd1;
                        if (o_last) n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_last    = (r_idx + 4'd1 == i_status.res_count);
    assign o_res_idx = r_idx;

endmodule

// File: rtl/ppmc_datapath.sv
// ============================================================================
// Panel controller datapath
// Pot filters, acceptance thresholds, snap pickup, mode state and results.
// ============================================================================
module ppmc_datapath
    import ppmc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_in_item   i_item,
    input  t_ctrl      i_ctrl,
    input  logic [3:0] i_res_idx,
    input  logic       i_last,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    output logic       o_func,
    output logic       o_button,
    output logic       o_is_long,
    output t_status    o_status,
    output t_out_item  o_item
);

    // Configuration registers.
    logic        r_snap;
    logic [15:0] r_long, r_unl, r_lck;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap <= 1'b0;
            r_long <= 16'd600;
            r_unl  <= 16'd64;
            r_lck  <= 16'd256;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SNAP:     r_snap <= i_cfg_data[0];
                REG_LONG:     r_long <= i_cfg_data;
                REG_UNLOCKED: r_unl  <= i_cfg_data;
                REG_LOCKED:   r_lck  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Held input item.
    t_in_item r_in;
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_item) r_in <= i_item;
    end

    assign o_func    = r_in.func;
    assign o_button  = r_in.button;
    assign o_is_long = r_in.press_ms > r_long;

    // Panel state.
    logic [15:0] r_filt [PotCount];
    logic [15:0] r_acc  [PotCount];
    logic [1:0]  r_cls  [PotCount];
    logic [7:0]  r_sb   [2*PotCount];
    logic        r_caught [PotCount];
    logic [1:0]  r_em;
    logic [2:0]  r_cf [2];

    // Result list: kinds decided at the step, replayed by index.
    typedef enum logic [1:0] {
        RL_NONE,
        RL_POT,
        RL_MODE,
        RL_FUNC
    } t_rlist;
    t_rlist      r_rl;
    logic [3:0]  r_cnt;
    logic [1:0]  r_pid;
    logic [15:0] r_pval;
    logic [1:0]  r_pmode;
    logic        r_pch;
    logic        r_flong;
    logic [2:0]  r_fval;

    // Pot and function arithmetic for the held item.
    logic [1:0]  w_id;
    logic [18:0] w_sum;
    logic [15:0] w_lp, w_cur, w_diff, w_thr;
    logic [7:0]  w_hi, w_sb, w_delta;
    logic        w_ch, w_take, w_ok;
    logic [2:0]  w_slot;
    logic [2:0]  w_f, w_nf;

    always_comb begin
        w_id   = r_in.pot_index;
        w_sum  = {3'b0, r_in.pot_raw} + {3'b0, r_filt[w_id]} * 19'd7;
        w_lp   = w_sum[18:3];
        w_cur  = r_acc[w_id];
        w_diff = (w_lp > w_cur) ? w_lp - w_cur : w_cur - w_lp;
        w_thr  = (r_cls[w_id] == CLS_LOCKED) ? r_lck : r_unl;
        w_take = (r_cls[w_id] == CLS_NONE) || (w_diff >= w_thr);
        w_hi   = w_lp[15:8];
        w_ch   = r_em[0];
        w_slot = {w_ch, w_id};
        w_sb   = r_sb[w_slot];
        w_delta = (w_sb > w_hi) ? w_sb - w_hi : w_hi - w_sb;
        w_ok   = !r_snap || r_caught[w_id] || (w_delta <= SNAP_WINDOW);
        w_f    = (r_em == EM_EXPERT2) ? r_cf[1] : r_cf[0];
        if (o_is_long) w_nf = w_f + 3'd4;
        else w_nf = {w_f[2], w_f[1:0] + 2'd1};
    end

    // State update on the step cycle; result count clear after the last result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PotCount; i++) begin
                r_filt[i]   <= '0;
                r_acc[i]    <= '0;
                r_cls[i]    <= CLS_NONE;
                r_caught[i] <= 1'b0;
            end
            for (int i = 0; i < 2*PotCount; i++) r_sb[i] <= '0;
            r_em    <= EM_TWIN;
            r_cf[0] <= '0;
            r_cf[1] <= '0;
            r_rl    <= RL_NONE;
            r_cnt   <= '0;
        end else begin
            unique case (i_ctrl.cmd)
                CMD_POT: begin
                    r_filt[w_id] <= w_lp;
                    r_rl  <= RL_POT;
                    r_pid <= w_id;
                    r_pval <= w_lp;
                    r_pmode <= r_em;
                    r_pch <= w_ch;
                    r_cnt <= '0;
                    if (w_take) begin
                        r_acc[w_id] <= w_lp;
                        r_cls[w_id] <= CLS_UNLOCKED;
                        if (r_em == EM_TWIN) begin
                            r_sb[{1'b0, w_id}] <= w_hi;
                            r_cnt <= 4'd2;
                        end else if (r_em == EM_SPLIT) begin
                            r_sb[{1'b0, w_id}] <= w_hi;
                            r_cnt <= 4'd1;
                        end else if (w_ok) begin
                            r_sb[w_slot] <= w_hi;
                            r_caught[w_id] <= 1'b1;
                            r_cnt <= 4'd1;
                        end
                    end
                end
                CMD_EDIT_LONG: begin
                    r_em    <= r_em + 2'd2;
                    r_cf[0] <= r_cf[1];
                    r_flong <= 1'b1;
                    r_rl    <= RL_MODE;
                    for (int i = 0; i < PotCount; i++) begin
                        r_cls[i]    <= CLS_LOCKED;
                        r_caught[i] <= 1'b0;
                    end
                    // New mode: twin or split gives full copy lists.
                    if (r_em + 2'd2 == EM_SPLIT) r_cnt <= 4'd8;
                    else if (r_em + 2'd2 == EM_TWIN) r_cnt <= 4'd12;
                    else r_cnt <= 4'd4;
                end
                CMD_EDIT_SHORT: begin
                    r_flong <= 1'b0;
                    r_rl    <= RL_MODE;
                    if (r_em <= EM_SPLIT) begin
                        r_em  <= EM_SPLIT - r_em;
                        r_cnt <= (r_em == EM_TWIN) ? 4'd6 : 4'd10;
                    end else begin
                        r_em  <= EM_EXPERT2 - {1'b0, r_em[0]};
                        r_cnt <= 4'd2;
                        for (int i = 0; i < PotCount; i++) begin
                            r_cls[i]    <= CLS_LOCKED;
                            r_caught[i] <= 1'b0;
                        end
                    end
                end
                CMD_FUNC: begin
                    r_rl   <= RL_FUNC;
                    r_fval <= w_nf;
                    r_pmode <= r_em;
                    if (r_em <= EM_SPLIT) begin
                        r_cf[0] <= w_nf;
                        r_cf[1] <= w_nf;
                        r_cnt   <= 4'd2;
                    end else begin
                        r_cf[r_em[0]] <= w_nf;
                        r_cnt <= 4'd1;
                    end
                end
                default: begin
                    if (i_ctrl.emit_step && i_last) r_cnt <= '0;
                end
            endcase
        end
    end

    assign o_status.res_count = r_cnt;

    // Result formation by index.
    logic [3:0] w_k;
    logic [1:0] w_pi;
    always_comb begin
        o_item = '0;
        o_item.edit_mode_now  = r_em;
        o_item.panel_function = (r_em == EM_EXPERT2) ? r_cf[1] : r_cf[0];
        o_item.last = i_last;
        w_k  = i_res_idx;
        w_pi = '0;
        case (r_rl)
            RL_POT: begin
                o_item.kind = KIND_PARAM;
                o_item.param_value = r_pval;
                if (r_pmode == EM_TWIN) begin
                    o_item.target = w_k[0];
                    o_item.param_index = r_pid;
                end else if (r_pmode == EM_SPLIT) begin
                    o_item.target = r_pid[1];
                    o_item.param_index = {1'b0, r_pid[0]};
                end else begin
                    o_item.target = r_pch;
                    o_item.param_index = r_pid;
                end
            end
            RL_FUNC: begin
                o_item.kind = KIND_FUNC;
                o_item.target = (r_pmode <= EM_SPLIT) ? w_k[0] : r_pmode[0];
                o_item.proc_function = proc_code(r_fval, o_item.target);
            end
            RL_MODE: begin
                // Optional leading function pair after a long press.
                if (r_flong && w_k < 4'd2) begin
                    o_item.kind = KIND_FUNC;
                    o_item.target = w_k[0];
                    o_item.proc_function = proc_code(r_cf[0], w_k[0]);
                end else begin
                    w_k = r_flong ? i_res_idx - 4'd2 : i_res_idx;
                    if (r_em == EM_SPLIT && w_k < 4'd4) begin
                        o_item.kind = KIND_PARAM;
                        o_item.target = w_k[1];
                        o_item.param_index = {1'b0, w_k[0]};
                        w_pi = {w_k[1], w_k[0]};
                        o_item.param_value = r_acc[w_pi];
                    end else if (r_em == EM_TWIN && w_k < 4'd8) begin
                        o_item.kind = KIND_PARAM;
                        o_item.target = w_k[2];
                        o_item.param_index = w_k[1:0];
                        w_pi = w_k[1:0];
                        o_item.param_value = r_acc[w_pi];
                    end else begin
                        o_item.kind = KIND_CMODE;
                        o_item.target = w_k[0];
                        o_item.control_mode = (r_em != EM_SPLIT);
                    end
                end
            end
            default: ;
        endcase
    end

endmodule

// File: rtl/ppmc_checker.sv
// ============================================================================
// Panel controller port checker
// Watches the top-level ports for handshake and sequencing errors.
// ============================================================================
module ppmc_checker
    import ppmc_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // No new input while results are pending.
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input open during results");

    // An accepted item blocks the input on the next cycle.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not closed after acceptance");

    // Result kind is always one of the defined codes.
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.kind <= KIND_CMODE)
        else $error("bad result kind");

endmodule

bind panel_pot_and_mode_controller_unit ppmc_checker u_ppmc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_stall (o_in_stall),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_item (o_out_item)
);

// File: tb/sv/panel_pot_and_mode_controller_unit_tb.sv
// ----------------------------------------------------------------------------
// Panel pot and mode controller testbench
// Drives pot samples and button releases through the stall handshake. A local
// model of the panel predicts every result, and each result is compared as
// a whole against the oldest prediction. Random stalls and gaps run on both
// sides, and the registers are rewritten between phases.
// ----------------------------------------------------------------------------
module panel_pot_and_mode_controller_unit_tb;
    import ppmc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CycleLimit = 400000;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    t_in_item   i_in_item;
    logic       o_out_valid;
    logic       i_out_stall;
    t_out_item  o_out_item;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index;
    logic [15:0] i_cfg_data;

    panel_pot_and_mode_controller_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Panel model state.
    logic        snap_on;
    logic [15:0] long_ms;
    logic [15:0] thr_unlocked;
    logic [15:0] thr_locked;
    logic [15:0] filt [PotCount];
    logic [15:0] accepted [PotCount];
    logic [1:0]  thr_class [PotCount];
    logic [7:0]  stored_hi [2*PotCount];
    logic        caught [PotCount];
    logic [1:0]  cur_mode;
    logic [2:0]  chan_func [2];

    t_out_item   pending_results [$];
    t_out_item   step_results [$];
    int          errors = 0;
    int          cycles = 0;
    bit          no_idle = 0;
    bit          hold_off = 0;

    // Clock.
    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    // Timeout.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic [3:0] to_proc(logic [2:0] f, logic ch);
        if (f < 3) return {1'b0, f};
        if (f == 3) return 4'd3 + ch;
        return {1'b0, f} + 4'd1;
    endfunction

    task automatic add_result(logic [1:0] kind, logic tgt, logic [1:0] pidx,
                              logic [15:0] pval, logic [3:0] pfn, logic cmode);
        t_out_item r;
        r = '0;
        r.kind = kind;
        r.target = tgt;
        r.param_index = pidx;
        r.param_value = pval;
        r.proc_function = pfn;
        r.control_mode = cmode;
        step_results.push_back(r);
    endtask

    task automatic lock_all();
        for (int i = 0; i < PotCount; i++) begin
            thr_class[i] = CLS_LOCKED;
            caught[i] = 0;
        end
    endtask

    task automatic announce_mode();
        if (cur_mode == EM_SPLIT) begin
            for (int i = 0; i < 2; i++) add_result(KIND_PARAM, 0, i, accepted[i], 0, 0);
            for (int i = 0; i < 2; i++) add_result(KIND_PARAM, 1, i, accepted[i+2], 0, 0);
            add_result(KIND_CMODE, 0, 0, 0, 0, 0);
            add_result(KIND_CMODE, 1, 0, 0, 0, 0);
        end else if (cur_mode == EM_TWIN) begin
            for (int i = 0; i < 4; i++) add_result(KIND_PARAM, 0, i, accepted[i], 0, 0);
            for (int i = 0; i < 4; i++) add_result(KIND_PARAM, 1, i, accepted[i], 0, 0);
            add_result(KIND_CMODE, 0, 0, 0, 0, 1);
            add_result(KIND_CMODE, 1, 0, 0, 0, 1);
        end else begin
            add_result(KIND_CMODE, 0, 0, 0, 0, 1);
            add_result(KIND_CMODE, 1, 0, 0, 0, 1);
        end
    endtask

    task automatic route_pot(int id, logic [15:0] v);
        logic [7:0] hi;
        int ch, slot, d;
        hi = v[15:8];
        if (cur_mode == EM_TWIN) begin
            add_result(KIND_PARAM, 0, id, v, 0, 0);
            add_result(KIND_PARAM, 1, id, v, 0, 0);
            stored_hi[id] = hi;
        end else if (cur_mode == EM_SPLIT) begin
            if (id < 2) add_result(KIND_PARAM, 0, id, v, 0, 0);
            else add_result(KIND_PARAM, 1, id - 2, v, 0, 0);
            stored_hi[id] = hi;
        end else begin
            ch = cur_mode - EM_EXPERT1;
            slot = id + ch * PotCount;
            d = int'(stored_hi[slot]) - int'(hi);
            if (d < 0) d = -d;
            if (!snap_on || caught[id] || d <= SNAP_WINDOW) begin
                add_result(KIND_PARAM, ch, id, v, 0, 0);
                stored_hi[slot] = hi;
                caught[id] = 1;
            end
        end
    endtask

    // Predicts the results of one accepted item and queues them.
    task automatic predict_panel(t_in_item it);
        logic [18:0] lp;
        int id, diff;
        logic [15:0] thr;
        logic is_long;
        logic [2:0] f;
        step_results.delete();
        if (!it.func) begin
            id = it.pot_index;
            lp = (19'(it.pot_raw) + 19'(filt[id]) * 7) >> 3;
            diff = int'(lp) - int'(accepted[id]);
            if (diff < 0) diff = -diff;
            thr = (thr_class[id] == CLS_LOCKED) ? thr_locked : thr_unlocked;
            filt[id] = lp[15:0];
            if (thr_class[id] == CLS_NONE || diff >= thr) begin
                route_pot(id, lp[15:0]);
                accepted[id] = lp[15:0];
                thr_class[id] = CLS_UNLOCKED;
            end
        end else begin
            is_long = it.press_ms > long_ms;
            if (!it.button) begin
                if (is_long) begin
                    cur_mode = cur_mode + 2'd2;
                    chan_func[0] = chan_func[1];
                    add_result(KIND_FUNC, 0, 0, 0, to_proc(chan_func[0], 0), 0);
                    add_result(KIND_FUNC, 1, 0, 0, to_proc(chan_func[0], 1), 0);
                    lock_all();
                end else if (cur_mode <= EM_SPLIT) begin
                    cur_mode = (cur_mode == EM_TWIN) ? EM_SPLIT : EM_TWIN;
                end else begin
                    cur_mode = (cur_mode == EM_EXPERT1) ? EM_EXPERT2 : EM_EXPERT1;
                    lock_all();
                end
                announce_mode();
            end else begin
                f = (cur_mode == EM_EXPERT2) ? chan_func[1] : chan_func[0];
                if (is_long) f = f + 3'd4;
                else if (f < 4) f = {1'b0, f[1:0] + 2'd1};
                else f = {1'b1, f[1:0] + 2'd1};
                if (cur_mode <= EM_SPLIT) begin
                    chan_func[0] = f;
                    chan_func[1] = f;
                    add_result(KIND_FUNC, 0, 0, 0, to_proc(f, 0), 0);
                    add_result(KIND_FUNC, 1, 0, 0, to_proc(f, 1), 0);
                end else begin
                    chan_func[cur_mode - EM_EXPERT1] = f;
                    add_result(KIND_FUNC, cur_mode - EM_EXPERT1, 0, 0,
                               to_proc(f, cur_mode - EM_EXPERT1), 0);
                end
            end
        end
        foreach (step_results[k]) begin
            step_results[k].edit_mode_now = cur_mode;
            step_results[k].panel_function =
                (cur_mode == EM_EXPERT2) ? chan_func[1] : chan_func[0];
            step_results[k].last = (k == step_results.size() - 1);
            pending_results.push_back(step_results[k]);
        end
    endtask

    // Result checking.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result expected none actual %p",
                         $time, o_out_item);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (want !== o_out_item) begin
                    $display("%0t: result mismatch expected %p actual %p",
                             $time, want, o_out_item);
                    errors++;
                end
            end
        end
    end

    // Receiver stall: random bursts, a long hold-off on request.
    initial begin
        int n;
        i_out_stall = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                i_out_stall <= 1;
                repeat (300) @(posedge i_clk);
                hold_off = 0;
                i_out_stall <= 0;
            end else if (!no_idle && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 10);
                i_out_stall <= 1;
                repeat (n - 1) @(posedge i_clk);
            end else begin
                i_out_stall <= 0;
            end
        end
    end

    task automatic cfg_write(logic [1:0] idx, logic [15:0] val);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
        case (idx)
            REG_SNAP:     snap_on = val[0];
            REG_LONG:     long_ms = val;
            REG_UNLOCKED: thr_unlocked = val;
            REG_LOCKED:   thr_locked = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Offers one transaction; valid stays high after acceptance until the next
    // call or a drain changes it, so each edge sees at most one update.
    task automatic send_item(t_in_item it, bit gaps);
        if (gaps && !no_idle && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_in_item <= it;
        do @(posedge i_clk); while (o_in_stall);
        predict_panel(it);
    endtask

    task automatic drain();
        i_in_valid <= 0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic t_in_item rand_item();
        t_in_item it;
        it = t_in_item'({$urandom, $urandom});
        if ($urandom_range(0, 9) < 7) begin
            it.func = 0;
            // Half of the samples move within 2048 of the current filtered value.
            if ($urandom_range(0, 1))
                it.pot_raw = filt[it.pot_index] + $urandom_range(0, 4095) - 2048;
        end else begin
            it.func = 1;
            case ($urandom_range(0, 3))
                0: it.press_ms = long_ms;
                1: it.press_ms = $urandom_range(0, 1200);
                default: ;
            endcase
        end
        return it;
    endfunction

    typedef struct {
        t_in_item  item;
        bit        known;
        t_out_item first;
    } t_dir_row;

    initial begin
        t_dir_row rows [$];
        t_dir_row row;
        t_in_item it;
        t_out_item r0;
        int pn;
        i_rst_n = 0;
        i_in_valid = 0;
        i_in_item = '0;
        i_cfg_valid = 0;
        i_cfg_index = REG_SNAP;
        i_cfg_data = '0;
        snap_on = 0; long_ms = 600; thr_unlocked = 64; thr_locked = 256;
        for (int i = 0; i < PotCount; i++) begin
            filt[i] = 0; accepted[i] = 0; thr_class[i] = CLS_NONE; caught[i] = 0;
        end
        for (int i = 0; i < 2*PotCount; i++) stored_hi[i] = 0;
        cur_mode = EM_TWIN;
        chan_func[0] = 0; chan_func[1] = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed table. The first row after reset has a known first result:
        // pot 0 at full scale filters to 8191 and goes to channel 0 in twin.
        row.item = '0; row.item.pot_raw = 16'hFFFF; row.known = 1;
        r0 = '0; r0.kind = KIND_PARAM; r0.param_value = 16'd8191;
        row.first = r0; rows.push_back(row);
        row.known = 0;
        row.item = '0; row.item.pot_index = 3; row.item.button = 1;
        row.item.press_ms = 16'hFFFF; rows.push_back(row);
        row.item = '0; row.item.func = 1; row.item.press_ms = 600;
        row.item.pot_raw = 16'hFFFF; row.item.pot_index = 3; rows.push_back(row);
        row.item = '0; row.item.func = 1; row.item.press_ms = 601; rows.push_back(row);
        row.item = '0; row.item.func = 1; row.item.button = 1; rows.push_back(row);
        row.item = '0; row.item.func = 1; row.item.button = 1;
        row.item.press_ms = 16'hFFFF; rows.push_back(row);
        for (int p = 0; p < 4; p++) begin
            row.item = '0; row.item.pot_index = p; row.item.pot_raw = 16'hFFFF;
            rows.push_back(row);
        end
        row.item = '0; row.item.func = 1; rows.push_back(row);
        row.item = '0; row.item.func = 1; row.item.press_ms = 16'hFFFF; rows.push_back(row);
        row.item = '0; row.item.func = 1; rows.push_back(row);
        row.item = '0; row.item.pot_index = 1; rows.push_back(row);
        row.item = '0; row.item.func = 1; row.item.button = 1; rows.push_back(row);
        foreach (rows[k]) begin
            send_item(rows[k].item, 0);
            // The newest predictions sit at the tail of the queue.
            pn = pending_results.size() - step_results.size();
            if (rows[k].known && pending_results[pn] !== rows[k].first) begin
                $display("%0t: table row %0d expected %p predicted %p",
                         $time, k, rows[k].first, pending_results[pn]);
                errors++;
            end
        end
        drain();

        // Snap on with extreme thresholds, then random phases.
        cfg_write(REG_SNAP, 1);
        cfg_write(REG_UNLOCKED, 1);
        cfg_write(REG_LOCKED, 16'hFFFF);
        cfg_write(REG_LONG, 0);
        for (int phase = 0; phase < 4; phase++) begin
            for (int n = 0; n < 100; n++) send_item(rand_item(), 1);
            if (phase == 1) begin
                // Long receiver hold-off while the sender keeps offering.
                hold_off = 1;
                for (int n = 0; n < 10; n++) send_item(rand_item(), 0);
            end
            drain();
            cfg_write(REG_SNAP, $urandom_range(0, 1));
            cfg_write(REG_LONG, phase == 2 ? 16'hFFFF : $urandom_range(0, 1200));
            cfg_write(REG_UNLOCKED, phase == 0 ? 16'hFFFF : $urandom_range(1, 600));
            cfg_write(REG_LOCKED, phase == 3 ? 16'd1 : $urandom_range(1, 2000));
        end
        // Final stretch without idling.
        no_idle = 1;
        for (int n = 0; n < 60; n++) send_item(rand_item(), 1);
        drain();
        repeat (20) @(posedge i_clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
